>>> rtl/core/pearson_matrix_profile_diagonal_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the diagonal matrix profile block
// expects clk and rst_n in the scope of use
// ---------------------------------------------------------------------------
`ifndef PEARSON_MATRIX_PROFILE_DIAGONAL_MACROS_SVH
`define PEARSON_MATRIX_PROFILE_DIAGONAL_MACROS_SVH

// same-cycle implication
`define PMPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pmpd_pkg.sv
// ---------------------------------------------------------------------------
// pmpd_pkg
// shared types and constants of the diagonal matrix profile block
// ---------------------------------------------------------------------------
package pmpd_pkg;

  localparam int unsigned SERIES_DEPTH_DEF = 4096;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_START   = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_LAG   = 2'd2;

  localparam logic REG_SERIES_LENGTH = 1'b0;
  localparam logic REG_MIN_LAG       = 1'b1;

  localparam logic signed [31:0] CORR_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] CORR_MINUS_ONE = -32'sh4000_0000;

endpackage

>>> rtl/core/pmpd_ram.sv
// ---------------------------------------------------------------------------
// pmpd_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module pmpd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pearson_matrix_profile_diagonal.sv
// ---------------------------------------------------------------------------
// pearson_matrix_profile_diagonal
// Diagonal-at-a-time Pearson matrix profile engine. Point values, diagonal
// covariances and the profile live in three synchronous rams. One request
// is handled at a time. Load, read, start and advance run from acceptance
// to the result register through a state sequence; the single shared
// 33x33 multiplier forms the two cross products and the 64x32x32
// correlation product in seven steps, after the separate ram reads of row
// and partner. A finished result waits in the output register while the
// next request is accepted. No clearing pass after reset.
// ---------------------------------------------------------------------------
`include "pearson_matrix_profile_diagonal_macros.svh"

module pearson_matrix_profile_diagonal #(
  parameter int unsigned SERIES_DEPTH = pmpd_pkg::SERIES_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [12:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [11:0]        in_row,
  input  logic [11:0]        in_lag,
  input  logic signed [31:0] in_half_diff,
  input  logic signed [31:0] in_centered_sum,
  input  logic [31:0]        in_inv_norm,
  input  logic signed [63:0] in_start_covariance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_correlation,
  output logic signed [31:0] out_best_correlation,
  output logic [11:0]        out_best_partner,
  output logic [1:0]         out_status
);

  localparam int unsigned AW = $clog2(SERIES_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RD0, S_RD1, S_RA, S_RB, S_MP1, S_MP2, S_MP3, S_ACC,
    S_ABS, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_RND, S_UPDR, S_UPDC,
    S_OUT
  } state_t;

  state_t state_r;

  logic [12:0]        series_len_r;
  logic [11:0]        min_lag_r;
  pmpd_pkg::mode_t    mode_r;
  logic [11:0]        row_r;
  logic [11:0]        lag_r;
  logic [12:0]        col_r;
  logic signed [31:0] df_in_r, dg_in_r;
  logic [31:0]        nv_in_r;
  logic signed [63:0] start_cov_r;

  logic signed [31:0] df_row_r, dg_row_r, df_col_r, dg_col_r;
  logic [31:0]        nv_row_r, nv_col_r;
  logic signed [63:0] cov_old_r, cov_new_r;
  logic [43:0]        prof_row_r, prof_col_r;
  logic signed [65:0] prod_r, p1_r;
  logic [63:0]        mag_r;
  logic               neg_r;
  logic [95:0]        a_r;
  logic [127:0]       c_r;
  logic signed [31:0] corr_r;
  logic signed [31:0] best_val_r;
  logic [11:0]        best_part_r;

  logic signed [31:0] res_corr_r, res_best_r;
  logic [11:0]        res_part_r;
  logic [1:0]         res_status_r;
  logic               res_pair_r;

  logic               out_valid_r;
  logic signed [31:0] out_corr_r, out_best_r;
  logic [11:0]        out_part_r;
  logic [1:0]         out_status_r;
  logic               out_pair_r;

  localparam logic [31:0] CORR_MINUS_ONE_W = pmpd_pkg::CORR_MINUS_ONE;

  // range checks on the incoming request
  logic [16:0] limit;
  logic [12:0] in_col;
  logic        row_bad, col_bad, lag_bad;

  assign limit   = ({4'b0, series_len_r} < 17'(SERIES_DEPTH)) ? {4'b0, series_len_r}
                                                            : 17'(SERIES_DEPTH);
  assign in_col  = {1'b0, in_row} + {1'b0, in_lag};
  assign row_bad = {5'b0, in_row} >= limit;
  assign col_bad = {4'b0, in_col} >= limit;
  assign lag_bad = in_lag < min_lag_r;

  assign in_ready = (state_r == S_IDLE);

  // covariance update, saturated to 64 bits; start mode loads the given start covariance
  logic signed [65:0] cov_sum;
  logic signed [63:0] cov_sat, cov_nxt;

  assign cov_sum = {{2{cov_old_r[63]}}, cov_old_r} + p1_r + prod_r;
  always_comb begin
    if (cov_sum[65:63] == 3'b000 || cov_sum[65:63] == 3'b111) begin
      cov_sat = cov_sum[63:0];
    end else if (cov_sum[65]) begin
      cov_sat = {1'b1, 63'd0};
    end else begin
      cov_sat = {1'b0, {63{1'b1}}};
    end
  end
  assign cov_nxt = (mode_r == pmpd_pkg::MODE_START) ? start_cov_r : cov_sat;

  // rams
  logic          pt_we;
  logic [95:0]   pt_rdata;
  logic [AW-1:0] pt_raddr;
  logic          cov_we;
  logic [63:0]   cov_rdata;
  logic          prof_we;
  logic [AW-1:0] prof_waddr, prof_raddr;
  logic [43:0]   prof_wdata, prof_rdata;

  logic signed [31:0] gt_row_val, col_cmp_val;
  logic               gt_row, gt_col;

  assign gt_row_val  = $signed(prof_row_r[43:12]);
  assign col_cmp_val = $signed(prof_col_r[43:12]);
  assign gt_row      = corr_r > gt_row_val;
  assign gt_col      = (corr_r > col_cmp_val) && (lag_r != 12'd0);

  assign pt_we    = (state_r == S_LOAD);
  assign pt_raddr = (state_r == S_RB) ? AW'(col_r) : AW'(row_r);
  assign cov_we   = (state_r == S_ACC);

  always_comb begin
    prof_we    = 1'b0;
    prof_waddr = AW'(row_r);
    prof_wdata = {CORR_MINUS_ONE_W, 12'd0};
    unique case (state_r)
      S_LOAD: begin
        prof_we = 1'b1;
      end
      S_UPDR: begin
        prof_we    = gt_row;
        prof_wdata = {corr_r, col_r[11:0]};
      end
      S_UPDC: begin
        prof_we    = gt_col;
        prof_waddr = AW'(col_r);
        prof_wdata = {corr_r, row_r};
      end
      default: begin
        prof_we = 1'b0;
      end
    endcase
  end

  assign prof_raddr = (state_r == S_RB) ? AW'(col_r) : AW'(row_r);

  pmpd_ram #(.WIDTH(96), .DEPTH(SERIES_DEPTH)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (AW'(row_r)),
    .wdata ({df_in_r, dg_in_r, nv_in_r}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  pmpd_ram #(.WIDTH(64), .DEPTH(SERIES_DEPTH)) u_cov_ram (
    .clk   (clk),
    .we    (cov_we),
    .waddr (AW'(lag_r)),
    .wdata (cov_nxt),
    .raddr (AW'(lag_r)),
    .rdata (cov_rdata)
  );

  pmpd_ram #(.WIDTH(44), .DEPTH(SERIES_DEPTH)) u_prof_ram (
    .clk   (clk),
    .we    (prof_we),
    .waddr (prof_waddr),
    .wdata (prof_wdata),
    .raddr (prof_raddr),
    .rdata (prof_rdata)
  );

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (state_r)
      S_MP2: begin
        mul_a = {df_row_r[31], df_row_r};
        mul_b = {dg_col_r[31], dg_col_r};
      end
      S_MP3: begin
        mul_a = {df_col_r[31], df_col_r};
        mul_b = {dg_row_r[31], dg_row_r};
      end
      S_M1: begin
        mul_a = {1'b0, mag_r[31:0]};
        mul_b = {1'b0, nv_row_r};
      end
      S_M2: begin
        mul_a = {1'b0, mag_r[63:32]};
        mul_b = {1'b0, nv_row_r};
      end
      S_M4: begin
        mul_a = {1'b0, a_r[31:0]};
        mul_b = {1'b0, nv_col_r};
      end
      S_M5: begin
        mul_a = {1'b0, a_r[63:32]};
        mul_b = {1'b0, nv_col_r};
      end
      S_M6: begin
        mul_a = {1'b0, a_r[95:64]};
        mul_b = {1'b0, nv_col_r};
      end
      default: begin
        mul_a = 33'sd0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding of the correlation magnitude
  logic [127:0] rnd_t;
  logic [31:0]  rnd_q;

  assign rnd_t = c_r + {78'd0, 1'b1, 49'd0};
  assign rnd_q = (rnd_t[127:80] != 48'd0) ? 32'(pmpd_pkg::CORR_ONE) : {2'b0, rnd_t[79:50]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      series_len_r <= 13'd4096;
      min_lag_r    <= 12'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          pmpd_pkg::REG_SERIES_LENGTH: series_len_r <= cfg_wdata;
          pmpd_pkg::REG_MIN_LAG:       min_lag_r    <= cfg_wdata[11:0];
          default:                     min_lag_r    <= min_lag_r;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r       <= pmpd_pkg::mode_t'(in_mode);
            row_r        <= in_row;
            lag_r        <= in_lag;
            col_r        <= in_col;
            df_in_r      <= in_half_diff;
            dg_in_r      <= in_centered_sum;
            nv_in_r      <= in_inv_norm;
            start_cov_r  <= in_start_covariance;
            res_corr_r   <= 32'sd0;
            res_best_r   <= 32'sd0;
            res_part_r   <= 12'd0;
            res_pair_r   <= 1'b0;
            if (in_mode == pmpd_pkg::MODE_LOAD || in_mode == pmpd_pkg::MODE_READ) begin
              if (row_bad) begin
                res_status_r <= pmpd_pkg::STAT_RANGE;
                state_r      <= S_OUT;
              end else if (in_mode == pmpd_pkg::MODE_LOAD) begin
                res_status_r <= pmpd_pkg::STAT_OK;
                state_r      <= S_LOAD;
              end else begin
                res_status_r <= pmpd_pkg::STAT_OK;
                state_r      <= S_RD0;
              end
            end else if (col_bad) begin
              res_status_r <= pmpd_pkg::STAT_RANGE;
              state_r      <= S_OUT;
            end else if (lag_bad) begin
              res_status_r <= pmpd_pkg::STAT_LAG;
              state_r      <= S_OUT;
            end else begin
              res_status_r <= pmpd_pkg::STAT_OK;
              state_r      <= S_RA;
            end
          end
        end
        S_LOAD: begin
          res_best_r <= pmpd_pkg::CORR_MINUS_ONE;
          state_r    <= S_OUT;
        end
        S_RD0: begin
          state_r <= S_RD1;
        end
        S_RD1: begin
          res_best_r <= $signed(prof_rdata[43:12]);
          res_part_r <= prof_rdata[11:0];
          state_r    <= S_OUT;
        end
        S_RA: begin
          state_r <= S_RB;
        end
        S_RB: begin
          df_row_r   <= $signed(pt_rdata[95:64]);
          dg_row_r   <= $signed(pt_rdata[63:32]);
          nv_row_r   <= pt_rdata[31:0];
          cov_old_r  <= $signed(cov_rdata);
          prof_row_r <= prof_rdata;
          state_r    <= S_MP1;
        end
        S_MP1: begin
          df_col_r   <= $signed(pt_rdata[95:64]);
          dg_col_r   <= $signed(pt_rdata[63:32]);
          nv_col_r   <= pt_rdata[31:0];
          prof_col_r <= prof_rdata;
          state_r    <= S_MP2;
        end
        S_MP2: begin
          prod_r  <= mul_p;
          state_r <= S_MP3;
        end
        S_MP3: begin
          p1_r    <= prod_r;
          prod_r  <= mul_p;
          state_r <= S_ACC;
        end
        S_ACC: begin
          cov_new_r <= cov_nxt;
          state_r   <= S_ABS;
        end
        S_ABS: begin
          neg_r   <= cov_new_r[63];
          mag_r   <= cov_new_r[63] ? (64'd0 - 64'(cov_new_r)) : 64'(cov_new_r);
          state_r <= S_M1;
        end
        S_M1: begin
          prod_r  <= mul_p;
          state_r <= S_M2;
        end
        S_M2: begin
          a_r     <= {32'd0, prod_r[63:0]};
          prod_r  <= mul_p;
          state_r <= S_M3;
        end
        S_M3: begin
          a_r     <= a_r + {prod_r[63:0], 32'd0};
          state_r <= S_M4;
        end
        S_M4: begin
          prod_r  <= mul_p;
          state_r <= S_M5;
        end
        S_M5: begin
          c_r     <= {64'd0, prod_r[63:0]};
          prod_r  <= mul_p;
          state_r <= S_M6;
        end
        S_M6: begin
          c_r     <= c_r + {32'd0, prod_r[63:0], 32'd0};
          prod_r  <= mul_p;
          state_r <= S_M7;
        end
        S_M7: begin
          c_r     <= c_r + {prod_r[63:0], 64'd0};
          state_r <= S_RND;
        end
        S_RND: begin
          corr_r  <= neg_r ? -$signed(rnd_q) : $signed(rnd_q);
          state_r <= S_UPDR;
        end
        S_UPDR: begin
          best_val_r  <= gt_row ? corr_r : gt_row_val;
          best_part_r <= gt_row ? col_r[11:0] : prof_row_r[11:0];
          state_r     <= S_UPDC;
        end
        S_UPDC: begin
          res_corr_r <= corr_r;
          res_best_r <= best_val_r;
          res_part_r <= best_part_r;
          res_pair_r <= 1'b1;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_corr_r   <= res_corr_r;
            out_best_r   <= res_best_r;
            out_part_r   <= res_part_r;
            out_status_r <= res_status_r;
            out_pair_r   <= res_pair_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_correlation      = out_corr_r;
  assign out_best_correlation = out_best_r;
  assign out_best_partner     = out_part_r;
  assign out_status           = out_status_r;

  `PMPD_ASSERT_IMP(a_best_not_below_corr, out_valid_r && out_pair_r,
                   out_best_r >= out_corr_r, "profile value below pair correlation")
  `PMPD_ASSERT_IMP(a_corr_in_range, state_r == S_UPDR,
                   (corr_r <= pmpd_pkg::CORR_ONE) && (corr_r >= pmpd_pkg::CORR_MINUS_ONE),
                   "correlation out of range")
  `PMPD_ASSERT_IMP(a_no_self_second_write, state_r == S_UPDC && prof_we,
                   lag_r != 12'd0, "self pair written twice")
  `PMPD_ASSERT_NXT(a_cov_then_abs, state_r == S_ACC,
                   state_r == S_ABS, "covariance step not followed by magnitude")

endmodule
